### hdl/src_over_pixel_blend_top_defines.svh
// ----------------------------------------------------------------------------
// Source-over pixel blend: assertion macros
// Clocked, reset-qualified property wrappers used by the top-level module's assertions.
// ----------------------------------------------------------------------------
`ifndef SRC_OVER_PIXEL_BLEND_TOP_DEFINES_SVH
`define SRC_OVER_PIXEL_BLEND_TOP_DEFINES_SVH

// Same-cycle implication on i_clk, disabled while i_rst_n is low
`define SPB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on i_clk, disabled while i_rst_n is low
`define SPB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/spb_pkg.sv
// ----------------------------------------------------------------------------
// Source-over pixel blend package
// Widths, constants, register codes and pipeline stage types.
// ----------------------------------------------------------------------------
package spb_pkg;

    localparam int unsigned ChanW    = 8;
    localparam int unsigned CovW     = 9;
    localparam int unsigned PosW     = 16;
    localparam int unsigned DimW     = 15;
    localparam int unsigned DenW     = 16;
    localparam int unsigned ProdW    = 16;
    localparam int unsigned RemW     = 24;
    localparam int unsigned QuotBits = 8;
    localparam int unsigned NumChan  = 3;
    localparam int unsigned ApbAddrW = 3;
    localparam int unsigned ApbDataW = 32;

    localparam int unsigned ChRed   = 0;
    localparam int unsigned ChGreen = 1;
    localparam int unsigned ChBlue  = 2;

    localparam logic [ChanW-1:0] MaxChannel = 8'd255;
    localparam logic [DimW-1:0]  DimReset   = 15'd1024;

    // floor(d / 255) == (d * 0x8081) >> 23 for every d below 2**16
    localparam logic [31:0]      RecipMul   = 32'h0000_8081;
    localparam int unsigned      RecipShift = 23;

    typedef enum logic {
        RegImgWidth  = 1'b0,
        RegImgHeight = 1'b1
    } t_reg;

    typedef logic [NumChan-1:0][ChanW-1:0] t_rgb;
    typedef logic [NumChan-1:0][ProdW-1:0] t_prod;
    typedef logic [NumChan-1:0][RemW-1:0]  t_rem;

    // bounds check and coverage scaling done
    typedef struct packed {
        logic             we;
        logic [ChanW-1:0] sa;
        t_rgb             src;
        t_rgb             dst;
        logic [ChanW-1:0] da;
    } t_s0;

    // products and denominator done
    typedef struct packed {
        logic             we;
        logic             pass_dst;
        logic [ChanW-1:0] inv;
        logic [DenW-1:0]  den;
        t_prod            ps;
        t_prod            pd;
        t_rgb             dst;
        logic [ChanW-1:0] da;
    } t_s1;

    // divider lane state, one per step
    typedef struct packed {
        logic             we;
        logic             pass_dst;
        logic [DenW-1:0]  den;
        logic [ChanW-1:0] alpha;
        t_rem             rem;
        t_rgb             quo;
        t_rgb             dst;
        logic [ChanW-1:0] da;
    } t_dv;

    typedef struct packed {
        logic             we;
        t_rgb             rgb;
        logic [ChanW-1:0] alpha;
    } t_res;

endpackage

### hdl/spb_pix_if.sv
// ----------------------------------------------------------------------------
// Pixel request channel
// Valid/ready channel carrying one pixel write request per word.
// ----------------------------------------------------------------------------
interface spb_pix_if;
    logic                                valid;
    logic                                ready;
    logic signed [spb_pkg::PosW-1:0]     pos_x;
    logic signed [spb_pkg::PosW-1:0]     pos_y;
    logic        [spb_pkg::ChanW-1:0]    dst_red;
    logic        [spb_pkg::ChanW-1:0]    dst_green;
    logic        [spb_pkg::ChanW-1:0]    dst_blue;
    logic        [spb_pkg::ChanW-1:0]    dst_alpha;
    logic        [spb_pkg::ChanW-1:0]    src_red;
    logic        [spb_pkg::ChanW-1:0]    src_green;
    logic        [spb_pkg::ChanW-1:0]    src_blue;
    logic        [spb_pkg::ChanW-1:0]    src_alpha;
    logic        [spb_pkg::CovW-1:0]     coverage;

    modport source (
        output valid, pos_x, pos_y, dst_red, dst_green, dst_blue, dst_alpha,
               src_red, src_green, src_blue, src_alpha, coverage,
        input  ready
    );

    modport sink (
        input  valid, pos_x, pos_y, dst_red, dst_green, dst_blue, dst_alpha,
               src_red, src_green, src_blue, src_alpha, coverage,
        output ready
    );
endinterface

### hdl/spb_res_if.sv
// ----------------------------------------------------------------------------
// Blend result channel
// Valid/ready channel carrying one blended pixel per word.
// ----------------------------------------------------------------------------
interface spb_res_if;
    logic                         valid;
    logic                         ready;
    logic                         write_enable;
    logic [spb_pkg::ChanW-1:0]    out_red;
    logic [spb_pkg::ChanW-1:0]    out_green;
    logic [spb_pkg::ChanW-1:0]    out_blue;
    logic [spb_pkg::ChanW-1:0]    out_alpha;

    modport source (
        output valid, write_enable, out_red, out_green, out_blue, out_alpha,
        input  ready
    );

    modport sink (
        input  valid, write_enable, out_red, out_green, out_blue, out_alpha,
        output ready
    );
endinterface

### hdl/src_over_pixel_blend_top.sv
// Throughput: one word per cycle; a stage holds only where the next one is full and cannot move on.
// Depth: bounds/coverage, products, numerator, eight restoring divide steps
//   (one quotient bit per stage, all three color lanes side by side), output.
// Reset: clears every stage valid and the output valid; width and height go to 1024.
// ----------------------------------------------------------------------------
// Source-over pixel blend, top level
// Bounds check, coverage scaling and exact integer source-over compositing.
// ----------------------------------------------------------------------------
`include "src_over_pixel_blend_top_defines.svh"

module src_over_pixel_blend_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    spb_pix_if.sink                       i_px,
    spb_res_if.source                     o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spb_pkg::ApbAddrW-1:0]  paddr,
    input  logic [spb_pkg::ApbDataW-1:0]  pwdata,
    output logic [spb_pkg::ApbDataW-1:0]  prdata,
    output logic                          pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [spb_pkg::DimW-1:0] r_width;
    logic [spb_pkg::DimW-1:0] r_height;
    spb_pkg::t_reg            w_reg;

    assign pready = 1'b1;
    assign w_reg  = spb_pkg::t_reg'(paddr[spb_pkg::ApbAddrW-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= spb_pkg::DimReset;
            r_height <= spb_pkg::DimReset;
        end else if (psel && penable && pwrite && pready) begin
            case (w_reg)
                spb_pkg::RegImgWidth:  r_width  <= pwdata[spb_pkg::DimW-1:0];
                spb_pkg::RegImgHeight: r_height <= pwdata[spb_pkg::DimW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            spb_pkg::RegImgWidth:  prdata = spb_pkg::ApbDataW'(r_width);
            spb_pkg::RegImgHeight: prdata = spb_pkg::ApbDataW'(r_height);
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage valids and advance chain
    // ------------------------------------------------------------------
    logic                        r_v_s0;
    logic                        r_v_s1;
    logic [spb_pkg::QuotBits:0]  r_v_dv;
    logic                        r_ov;

    logic                        w_adv_s0;
    logic                        w_adv_s1;
    logic [spb_pkg::QuotBits:0]  w_adv_dv;
    logic                        w_adv_o;

    // a stage may load when it is empty or its word moves on this cycle
    always_comb begin
        w_adv_o = !r_ov || o_res.ready;
        w_adv_dv[spb_pkg::QuotBits] = !r_v_dv[spb_pkg::QuotBits] || w_adv_o;
        for (int k = spb_pkg::QuotBits - 1; k >= 0; k--) begin
            w_adv_dv[k] = !r_v_dv[k] || w_adv_dv[k+1];
        end
        w_adv_s1 = !r_v_s1 || w_adv_dv[0];
        w_adv_s0 = !r_v_s0 || w_adv_s1;
    end

    assign i_px.ready = w_adv_s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_s0 <= 1'b0;
            r_v_s1 <= 1'b0;
            r_v_dv <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (w_adv_s0) begin
                r_v_s0 <= i_px.valid;
            end
            if (w_adv_s1) begin
                r_v_s1 <= r_v_s0;
            end
            if (w_adv_dv[0]) begin
                r_v_dv[0] <= r_v_s1;
            end
            for (int k = 1; k <= spb_pkg::QuotBits; k++) begin
                if (w_adv_dv[k]) begin
                    r_v_dv[k] <= r_v_dv[k-1];
                end
            end
            if (w_adv_o) begin
                r_ov <= r_v_dv[spb_pkg::QuotBits];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: bounds check, coverage scaling of source alpha
    // ------------------------------------------------------------------
    spb_pkg::t_s0              r_s0;
    spb_pkg::t_s0              n_s0;
    logic                      w_inside;
    logic [spb_pkg::ProdW-1:0] w_cov_prod;

    always_comb begin
        w_inside = !i_px.pos_x[spb_pkg::PosW-1] && !i_px.pos_y[spb_pkg::PosW-1] &&
                   (i_px.pos_x[spb_pkg::DimW-1:0] < r_width) &&
                   (i_px.pos_y[spb_pkg::DimW-1:0] < r_height);
        w_cov_prod = i_px.src_alpha * i_px.coverage[spb_pkg::ChanW-1:0];

        n_s0.we = w_inside && (i_px.coverage != '0);
        // full coverage and above keep the paint alpha; otherwise truncate the Q8 scale
        n_s0.sa = i_px.coverage[spb_pkg::CovW-1] ? i_px.src_alpha
                : w_cov_prod[spb_pkg::ProdW-1 -: spb_pkg::ChanW];
        n_s0.src[spb_pkg::ChRed]   = i_px.src_red;
        n_s0.src[spb_pkg::ChGreen] = i_px.src_green;
        n_s0.src[spb_pkg::ChBlue]  = i_px.src_blue;
        n_s0.dst[spb_pkg::ChRed]   = i_px.dst_red;
        n_s0.dst[spb_pkg::ChGreen] = i_px.dst_green;
        n_s0.dst[spb_pkg::ChBlue]  = i_px.dst_blue;
        n_s0.da = i_px.dst_alpha;
    end

    // ------------------------------------------------------------------
    // Stage 1: per-lane products and the shared denominator
    // ------------------------------------------------------------------
    spb_pkg::t_s1 r_s1;
    spb_pkg::t_s1 n_s1;

    always_comb begin
        n_s1.we       = r_s0.we;
        n_s1.pass_dst = (r_s0.sa == '0);
        n_s1.inv      = spb_pkg::MaxChannel - r_s0.sa;
        // sa*255 + da*(255-sa), never above 255*255
        n_s1.den      = ({r_s0.sa, {spb_pkg::ChanW{1'b0}}} - spb_pkg::DenW'(r_s0.sa)) +
                        r_s0.da * n_s1.inv;
        for (int c = 0; c < spb_pkg::NumChan; c++) begin
            n_s1.ps[c] = r_s0.src[c] * r_s0.sa;
            n_s1.pd[c] = r_s0.dst[c] * r_s0.da;
        end
        n_s1.dst = r_s0.dst;
        n_s1.da  = r_s0.da;
    end

    // ------------------------------------------------------------------
    // Stage 2 (divider entry) and the restoring divide steps
    // ------------------------------------------------------------------
    spb_pkg::t_dv              r_dv [spb_pkg::QuotBits+1];
    spb_pkg::t_dv              n_dv [spb_pkg::QuotBits+1];
    logic [31:0]               w_alpha_prod;
    logic [spb_pkg::RemW-1:0]  w_trial;
    logic                      w_ge;

    always_comb begin
        w_alpha_prod = spb_pkg::RemW'(r_s1.den) * spb_pkg::RecipMul;
        w_trial      = '0;
        w_ge         = 1'b0;

        n_dv[0].we       = r_s1.we;
        n_dv[0].pass_dst = r_s1.pass_dst;
        n_dv[0].den      = r_s1.den;
        n_dv[0].alpha    = w_alpha_prod[spb_pkg::RecipShift +: spb_pkg::ChanW];
        n_dv[0].quo      = '0;
        n_dv[0].dst      = r_s1.dst;
        n_dv[0].da       = r_s1.da;
        // numerator s*sa*255 + d*da*(255-sa)
        for (int c = 0; c < spb_pkg::NumChan; c++) begin
            n_dv[0].rem[c] = ({r_s1.ps[c], {spb_pkg::ChanW{1'b0}}} -
                              spb_pkg::RemW'(r_s1.ps[c])) +
                             spb_pkg::RemW'(r_s1.pd[c]) * spb_pkg::RemW'(r_s1.inv);
        end

        // one quotient bit per step, MSB first, shifted into the lane
        for (int k = 0; k < spb_pkg::QuotBits; k++) begin
            n_dv[k+1] = r_dv[k];
            for (int c = 0; c < spb_pkg::NumChan; c++) begin
                w_trial = spb_pkg::RemW'(r_dv[k].den) << (spb_pkg::QuotBits - 1 - k);
                w_ge    = (r_dv[k].rem[c] >= w_trial);
                if (w_ge) begin
                    n_dv[k+1].rem[c] = r_dv[k].rem[c] - w_trial;
                end
                n_dv[k+1].quo[c] = {r_dv[k].quo[c][spb_pkg::ChanW-2:0], w_ge};
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: zero the pixel of disabled words, pass destination on zero alpha
    // ------------------------------------------------------------------
    spb_pkg::t_res r_o;
    spb_pkg::t_res n_o;

    always_comb begin
        n_o.we    = r_dv[spb_pkg::QuotBits].we;
        n_o.rgb   = r_dv[spb_pkg::QuotBits].quo;
        n_o.alpha = r_dv[spb_pkg::QuotBits].alpha;
        if (!r_dv[spb_pkg::QuotBits].we) begin
            n_o.rgb   = '0;
            n_o.alpha = '0;
        end else if (r_dv[spb_pkg::QuotBits].pass_dst) begin
            n_o.rgb   = r_dv[spb_pkg::QuotBits].dst;
            n_o.alpha = r_dv[spb_pkg::QuotBits].da;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_s0) begin
            r_s0 <= n_s0;
        end
        if (w_adv_s1) begin
            r_s1 <= n_s1;
        end
        for (int k = 0; k <= spb_pkg::QuotBits; k++) begin
            if (w_adv_dv[k]) begin
                r_dv[k] <= n_dv[k];
            end
        end
        if (w_adv_o) begin
            r_o <= n_o;
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.write_enable = r_o.we;
    assign o_res.out_red      = r_o.rgb[spb_pkg::ChRed];
    assign o_res.out_green    = r_o.rgb[spb_pkg::ChGreen];
    assign o_res.out_blue     = r_o.rgb[spb_pkg::ChBlue];
    assign o_res.out_alpha    = r_o.alpha;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SPB_ASSERT_IMP(a_ready_when_drained, !r_ov, i_px.ready, "input held off with an empty output register")
    `SPB_ASSERT_NXT(a_stalled_word_kept, r_v_dv[spb_pkg::QuotBits] && !w_adv_dv[spb_pkg::QuotBits], r_v_dv[spb_pkg::QuotBits], "stalled divider word lost")
    `SPB_ASSERT_IMP(a_rem_below_den, r_v_dv[spb_pkg::QuotBits] && r_dv[spb_pkg::QuotBits].we && !r_dv[spb_pkg::QuotBits].pass_dst, (r_dv[spb_pkg::QuotBits].rem[spb_pkg::ChRed] < r_dv[spb_pkg::QuotBits].den) && (r_dv[spb_pkg::QuotBits].rem[spb_pkg::ChGreen] < r_dv[spb_pkg::QuotBits].den) && (r_dv[spb_pkg::QuotBits].rem[spb_pkg::ChBlue] < r_dv[spb_pkg::QuotBits].den), "divider remainder not below denominator")
    `SPB_ASSERT_IMP(a_no_write_zero, o_res.valid && !o_res.write_enable, (o_res.out_red == '0) && (o_res.out_green == '0) && (o_res.out_blue == '0) && (o_res.out_alpha == '0), "disabled word carries nonzero pixel")

endmodule
